[design/elti_pkg.sv]
// Constants and tables for the energy-loss table interpolator.
package elti_pkg;

	localparam int NUM_EDGES_DEF = 38;
	localparam int TABLE_LEN     = 38;

	localparam int QP_W   = 32;
	localparam int PID_W  = 3;
	localparam int MOM_W  = 28;
	localparam int LOSS_W = 26;
	localparam int BIN_W  = 6;
	localparam int SCL_W  = 16;
	localparam int TAB_W  = 21;
	localparam int DX_W   = 18;
	localparam int DIF_W  = 20;
	localparam int RAT_W  = 17;

	localparam int REC_STEPS = 28;
	localparam int DIV_STEPS = 20;

	localparam logic [MOM_W-1:0] P_MAX     = 28'hFFFFFFF;
	localparam logic [MOM_W-1:0] P_DEFAULT = 28'd2560000;
	localparam logic [31:0]      REC_SAT   = 32'd1024;
	localparam logic [31:0]      REC_INIT  = 32'd1024;
	localparam logic [25:0]      SAT_MAG   = 26'h2000000;

	localparam logic [SCL_W-1:0] LOSS_SCALE_RST = 16'd4096;
	localparam logic [2:0]       REG_LOSS_SCALE = 3'd0;

	typedef enum logic [PID_W-1:0] {
		PID_MUON     = 3'd0,
		PID_ELECTRON = 3'd1,
		PID_PION     = 3'd2,
		PID_PROTON   = 3'd3,
		PID_KAON     = 3'd4
	} pid_t;

	localparam logic [RAT_W-1:0] RAT_PION   = 17'd49613;
	localparam logic [RAT_W-1:0] RAT_PROTON = 17'd7380;
	localparam logic [RAT_W-1:0] RAT_KAON   = 17'd14026;
	localparam logic [RAT_W-1:0] RAT_UNITY  = 17'd65536;

	localparam logic [MOM_W-1:0] EDGE_TAB [TABLE_LEN] = '{
		28'd0, 28'd1280, 28'd2560, 28'd3840, 28'd5120, 28'd6400, 28'd7680, 28'd8960,
		28'd10240, 28'd11520, 28'd12800, 28'd14080, 28'd15360, 28'd16640, 28'd17920,
		28'd19200, 28'd20480, 28'd21760, 28'd23040, 28'd24320, 28'd25600, 28'd30720,
		28'd35840, 28'd40960, 28'd46080, 28'd51200, 28'd76800, 28'd102400, 28'd128000,
		28'd153600, 28'd179200, 28'd204800, 28'd230400, 28'd256000, 28'd512000,
		28'd768000, 28'd1024000, 28'd1280000
	};

	localparam logic [TAB_W-1:0] MUON_TAB [TABLE_LEN] = '{
		21'd1208484, 21'd1015808, 21'd454164, 21'd263455, 21'd175047, 21'd126681,
		21'd97124, 21'd77791, 21'd64356, 21'd54591, 21'd47383, 21'd41812, 21'd37487,
		21'd34013, 21'd31195, 21'd28901, 21'd27001, 21'd25362, 21'd23986, 21'd22872,
		21'd20316, 21'd17695, 21'd15991, 21'd14942, 21'd14221, 21'd13238, 21'd12780,
		21'd12845, 21'd13042, 21'd13238, 21'd13500, 21'd13697, 21'd13894, 21'd14680,
		21'd15860, 21'd16581, 21'd17105, 21'd17957
	};

	localparam logic [TAB_W-1:0] ELEC_TAB [TABLE_LEN] = '{
		21'd157286, 21'd16056, 21'd16318, 21'd16843, 21'd17433, 21'd17760, 21'd18088,
		21'd18285, 21'd18547, 21'd18743, 21'd18940, 21'd19071, 21'd19202, 21'd19333,
		21'd19464, 21'd19530, 21'd19595, 21'd19726, 21'd19792, 21'd19857, 21'd19923,
		21'd20120, 21'd20251, 21'd20382, 21'd20447, 21'd20644, 21'd20840, 21'd20906,
		21'd20972, 21'd21037, 21'd21037, 21'd21037, 21'd21103, 21'd21103, 21'd21168,
		21'd21168, 21'd21168, 21'd21430
	};

	function automatic logic [RAT_W-1:0] mass_ratio(input logic [PID_W-1:0] pid);
		logic [RAT_W-1:0] r;
		case (pid)
			PID_PION:   r = RAT_PION;
			PID_PROTON: r = RAT_PROTON;
			PID_KAON:   r = RAT_KAON;
			default:    r = RAT_UNITY;
		endcase
		return r;
	endfunction

endpackage

[design/energy_loss_table_interpolator.sv]
// Pipelined momentum reciprocal, table bin search and linear interpolation of dE/dx.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    tdata q_over_p, tuser particle_id
//  m_axis    out  m_tvalid/m_tready    tdata energy_loss, momentum_bin
//  apb       in   psel/penable/pwrite  loss_scale at address 0
//
// One request per cycle while the skid entry is empty; a full skid drops s_tready.
// The depth is set by the 28-step reciprocal divider and the 20-step
// interpolation divider, one quotient bit per stage.
// Reset clears all valid bits and sets loss_scale to 1.0.
// A two-entry output (register plus skid) lets the pipe freeze on a full skid only.
module energy_loss_table_interpolator import elti_pkg::*; #(
	parameter int NUM_EDGES = NUM_EDGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] q_over_p
	input  logic [2:0]  s_tuser,   // [2:0] particle_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [25:0] energy_loss, [31:26] momentum_bin
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NU = (NUM_EDGES > TABLE_LEN) ? TABLE_LEN :
		((NUM_EDGES < 2) ? 2 : NUM_EDGES);
	localparam int NC = NU - 1;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NU - 1);

	// configuration
	logic [SCL_W-1:0] loss_scale_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LOSS_SCALE) ? {16'd0, loss_scale_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_scale_q <= LOSS_SCALE_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_LOSS_SCALE) begin
			loss_scale_q <= pwdata[SCL_W-1:0];
		end
	end

	logic pipe_en;
	logic skid_full_q;
	assign pipe_en  = !skid_full_q;
	assign s_tready = pipe_en;

	// stage 1: magnitude, held in entry 0 of the reciprocal pipe
	logic [32:0]      mag_c;

	assign mag_c = s_tdata[31] ? (33'h100000000 - {1'b0, s_tdata}) : {1'b0, s_tdata};

	// reciprocal: 2^38 / mag, one quotient bit per stage
	logic             rec_v_s   [REC_STEPS+1];
	logic [31:0]      rec_rem_s [REC_STEPS+1];
	logic [MOM_W-1:0] rec_quo_s [REC_STEPS+1];
	logic [31:0]      rec_mag_s [REC_STEPS+1];
	logic             rec_zero_s[REC_STEPS+1];
	logic             rec_sat_s [REC_STEPS+1];
	logic [PID_W-1:0] rec_pid_s [REC_STEPS+1];
	logic [31:0]      rec_rem_c [REC_STEPS];
	logic             rec_bit_c [REC_STEPS];

	always_comb begin
		logic [31:0] sh;
		logic [32:0] tr;
		for (int k = 0; k < REC_STEPS; k++) begin
			sh = {rec_rem_s[k][30:0], 1'b0};
			tr = {1'b0, sh} - {1'b0, rec_mag_s[k]};
			rec_bit_c[k] = !tr[32];
			rec_rem_c[k] = tr[32] ? sh : tr[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= REC_STEPS; k++) rec_v_s[k] <= 1'b0;
		end else if (pipe_en) begin
			rec_v_s[0] <= s_tvalid;
			for (int k = 1; k <= REC_STEPS; k++) rec_v_s[k] <= rec_v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rec_rem_s[0]  <= REC_INIT;
			rec_quo_s[0]  <= '0;
			rec_mag_s[0]  <= mag_c[31:0];
			rec_zero_s[0] <= (s_tdata == 32'd0);
			rec_sat_s[0]  <= (mag_c[31:0] <= REC_SAT);
			rec_pid_s[0]  <= s_tuser;
			for (int k = 1; k <= REC_STEPS; k++) begin
				rec_rem_s[k]  <= rec_rem_c[k-1];
				rec_quo_s[k]  <= {rec_quo_s[k-1][MOM_W-2:0], rec_bit_c[k-1]};
				rec_mag_s[k]  <= rec_mag_s[k-1];
				rec_zero_s[k] <= rec_zero_s[k-1];
				rec_sat_s[k]  <= rec_sat_s[k-1];
				rec_pid_s[k]  <= rec_pid_s[k-1];
			end
		end
	end

	// stage 2: momentum select and mass scaling
	logic             v_s2;
	logic [MOM_W-1:0] ps_s2;
	logic [PID_W-1:0] pid_s2;
	logic [MOM_W-1:0] p_c;
	logic [MOM_W+RAT_W-1:0] pm_c;

	always_comb begin
		if (rec_zero_s[REC_STEPS])     p_c = P_DEFAULT;
		else if (rec_sat_s[REC_STEPS]) p_c = P_MAX;
		else                           p_c = rec_quo_s[REC_STEPS];
		pm_c = p_c * mass_ratio(rec_pid_s[REC_STEPS]);
	end

	// stage 3: edge compares; stage 4: bin
	logic             v_s3, v_s4;
	logic [NC-1:0]    ge_s3;
	logic [MOM_W-1:0] ps_s3, ps_s4;
	logic [PID_W-1:0] pid_s3, pid_s4;
	logic [BIN_W-1:0] bin_s4;
	logic [NC-1:0]    ge_c;

	always_comb begin
		for (int i = 0; i < NC; i++) ge_c[i] = (ps_s2 >= EDGE_TAB[i+1]);
	end

	// stage 5: table fetch
	logic             v_s5;
	logic [DX_W-1:0]  dx_s5, wd_s5;
	logic [DIF_W-1:0] dif_s5;
	logic             up_s5, last_s5;
	logic [TAB_W-1:0] lo_s5;
	logic [BIN_W-1:0] bin_s5;
	logic [BIN_W-1:0] hi_idx;
	logic [TAB_W-1:0] lo_c, hi_c;
	logic             last_c;
	logic [MOM_W-1:0] dx_c, wd_c;

	always_comb begin
		last_c = (bin_s4 >= LAST_BIN);
		hi_idx = last_c ? bin_s4 : bin_s4 + BIN_W'(1);
		if (pid_s4 == PID_ELECTRON) begin
			lo_c = ELEC_TAB[bin_s4];
			hi_c = ELEC_TAB[hi_idx];
		end else begin
			lo_c = MUON_TAB[bin_s4];
			hi_c = MUON_TAB[hi_idx];
		end
		dx_c = ps_s4 - EDGE_TAB[bin_s4];
		wd_c = EDGE_TAB[hi_idx] - EDGE_TAB[bin_s4];
	end

	// stage 6: dx * |hi - lo|, held in entry 0 of the divider pipe
	logic [DX_W+DIF_W-1:0] pr_c;

	assign pr_c = last_s5 ? '0 : dx_s5 * dif_s5;

	// interpolation divide by bin width, one quotient bit per stage
	logic                  dv_v_s   [DIV_STEPS+1];
	logic [DX_W-1:0]       dv_rem_s [DIV_STEPS+1];
	logic [DIF_W-1:0]      dv_low_s [DIV_STEPS+1];
	logic [DIF_W-1:0]      dv_quo_s [DIV_STEPS+1];
	logic [DX_W-1:0]       dv_wd_s  [DIV_STEPS+1];
	logic                  dv_up_s  [DIV_STEPS+1];
	logic                  dv_last_s[DIV_STEPS+1];
	logic [TAB_W-1:0]      dv_lo_s  [DIV_STEPS+1];
	logic [BIN_W-1:0]      dv_bin_s [DIV_STEPS+1];
	logic [DX_W-1:0]       dv_rem_c [DIV_STEPS];
	logic                  dv_bit_c [DIV_STEPS];

	always_comb begin
		logic [DX_W:0]   sh;
		logic [DX_W+1:0] tr;
		for (int k = 0; k < DIV_STEPS; k++) begin
			sh = {dv_rem_s[k], dv_low_s[k][DIF_W-1]};
			tr = {1'b0, sh} - {2'b00, dv_wd_s[k]};
			dv_bit_c[k] = !tr[DX_W+1];
			dv_rem_c[k] = tr[DX_W+1] ? sh[DX_W-1:0] : tr[DX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) dv_v_s[k] <= 1'b0;
		end else if (pipe_en) begin
			dv_v_s[0] <= v_s5;
			for (int k = 1; k <= DIV_STEPS; k++) dv_v_s[k] <= dv_v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dv_rem_s[0]  <= pr_c[DX_W+DIF_W-1:DIF_W];
			dv_low_s[0]  <= pr_c[DIF_W-1:0];
			dv_quo_s[0]  <= '0;
			dv_wd_s[0]   <= wd_s5;
			dv_up_s[0]   <= up_s5;
			dv_last_s[0] <= last_s5;
			dv_lo_s[0]   <= lo_s5;
			dv_bin_s[0]  <= bin_s5;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_rem_s[k]  <= dv_rem_c[k-1];
				dv_low_s[k]  <= {dv_low_s[k-1][DIF_W-2:0], 1'b0};
				dv_quo_s[k]  <= {dv_quo_s[k-1][DIF_W-2:0], dv_bit_c[k-1]};
				dv_wd_s[k]   <= dv_wd_s[k-1];
				dv_up_s[k]   <= dv_up_s[k-1];
				dv_last_s[k] <= dv_last_s[k-1];
				dv_lo_s[k]   <= dv_lo_s[k-1];
				dv_bin_s[k]  <= dv_bin_s[k-1];
			end
		end
	end

	// stage 7: interpolated value; stage 8: scale; stage 9: saturate and negate
	logic                   v_s7, v_s8, v_s9;
	logic [TAB_W-1:0]       val_s7;
	logic [BIN_W-1:0]       bin_s7, bin_s8, bin_s9;
	logic [TAB_W+SCL_W-1:0] mv_s8;
	logic [LOSS_W-1:0]      loss_s9;
	logic [TAB_W-1:0]       val_c;
	logic [TAB_W+SCL_W-13:0] sc_c;
	logic [25:0]            mag_sat_c;

	always_comb begin
		if (dv_last_s[DIV_STEPS])    val_c = dv_lo_s[DIV_STEPS];
		else if (dv_up_s[DIV_STEPS]) val_c = dv_lo_s[DIV_STEPS] + TAB_W'(dv_quo_s[DIV_STEPS]);
		else                         val_c = dv_lo_s[DIV_STEPS] - TAB_W'(dv_quo_s[DIV_STEPS]);
		sc_c = mv_s8[TAB_W+SCL_W-1:12];
		mag_sat_c = ({1'b0, sc_c} > SAT_MAG) ? SAT_MAG : {1'b0, sc_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= rec_v_s[REC_STEPS];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s7 <= dv_v_s[DIV_STEPS];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ps_s2   <= pm_c[MOM_W+16-1:16];
			pid_s2  <= rec_pid_s[REC_STEPS];
			ge_s3   <= ge_c;
			ps_s3   <= ps_s2;
			pid_s3  <= pid_s2;
			bin_s4  <= BIN_W'($countones(ge_s3));
			ps_s4   <= ps_s3;
			pid_s4  <= pid_s3;
			dx_s5   <= dx_c[DX_W-1:0];
			wd_s5   <= last_c ? DX_W'(1) : wd_c[DX_W-1:0];
			up_s5   <= (hi_c >= lo_c);
			dif_s5  <= (hi_c >= lo_c) ? DIF_W'(hi_c - lo_c) : DIF_W'(lo_c - hi_c);
			lo_s5   <= lo_c;
			last_s5 <= last_c;
			bin_s5  <= bin_s4;
			val_s7  <= val_c;
			bin_s7  <= dv_bin_s[DIV_STEPS];
			mv_s8   <= val_s7 * loss_scale_q;
			bin_s8  <= bin_s7;
			loss_s9 <= LOSS_W'(26'd0 - mag_sat_c);
			bin_s9  <= bin_s8;
		end
	end

	// output register with skid entry
	logic        out_valid_q;
	logic [31:0] out_data_q, skid_data_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (skid_full_q) begin
				if (m_tready) skid_full_q <= 1'b0;
			end else if (v_s9) begin
				if (!out_valid_q || m_tready) out_valid_q <= 1'b1;
				else                          skid_full_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (m_tready) out_data_q <= skid_data_q;
		end else if (v_s9) begin
			if (!out_valid_q || m_tready) out_data_q  <= {bin_s9, loss_s9};
			else                          skid_data_q <= {bin_s9, loss_s9};
		end
	end

endmodule
